>>> rtl/core/amat_pkg.sv
// Shared widths, function codes and the per-cell control bundle of the
// all-patterns substring matcher. No dependencies.
`timescale 1ns / 1ps

package amat_pkg;

	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 3;
	localparam int POS_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 4;
	localparam int MASK_W  = 8;

	// Load positions are POS_W bits wide, so no more cells than this can be filled.
	localparam int MAX_CELLS = 1 << POS_W;

	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SCAN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_END  = 2'd2;

	typedef struct packed {
		logic              shift;
		logic              clear;
		logic              load;
		logic [IDX_W-1:0]  load_idx;
		logic [POS_W-1:0]  load_pos;
		logic [BYTE_W-1:0] load_byte;
	} cell_ctl_t;

endpackage

>>> rtl/core/amat_item_if.sv
// Input channel of the matcher: valid/ready handshake plus one item.
// Depends on amat_pkg.
`timescale 1ns / 1ps

interface amat_item_if import amat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  pattern_index;
	logic [POS_W-1:0]  pattern_pos;
	logic [BYTE_W-1:0] byte_value;
	logic              last;

	modport source (
		output valid, func, pattern_index, pattern_pos, byte_value, last,
		input  ready
	);
	modport sink (
		input  valid, func, pattern_index, pattern_pos, byte_value, last,
		output ready
	);
endinterface

>>> rtl/core/amat_result_if.sv
// Output channel of the matcher: valid/ready handshake plus one result.
// Depends on amat_pkg.
`timescale 1ns / 1ps

interface amat_result_if import amat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              detected;
	logic [MASK_W-1:0] found_mask;
	logic              content_stopped;

	modport source (
		output valid, detected, found_mask, content_stopped,
		input  ready
	);
	modport sink (
		input  valid, detected, found_mask, content_stopped,
		output ready
	);
endinterface

>>> rtl/core/amat_cell.sv
// One cell of the history chain: a history byte, the stored pattern bytes at
// this position, and per-pattern aligned bytes compared against the history.
// Depends on amat_pkg.
`timescale 1ns / 1ps

module amat_cell import amat_pkg::*; #(
	parameter int NUM_PATTERNS = 8,
	parameter int INDEX        = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [BYTE_W-1:0]       hist_in,
	output logic [BYTE_W-1:0]       hist_out,
	output logic [BYTE_W-1:0]       store_byte [NUM_PATTERNS],
	input  logic [BYTE_W-1:0]       aligned_d  [NUM_PATTERNS],
	output logic [NUM_PATTERNS-1:0] hit
);

	logic [BYTE_W-1:0] hist_q;
	logic [BYTE_W-1:0] store_q   [NUM_PATTERNS];
	logic [BYTE_W-1:0] aligned_q [NUM_PATTERNS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.clear) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= hist_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			if (ctl.load && ctl.load_pos == POS_W'(INDEX) && int'(ctl.load_idx) == p) begin
				store_q[p] <= ctl.load_byte;
			end
		end
	end

	// The aligned bytes are recomputed from the store every cycle, so a load
	// reaches them via store_q and then aligned_q; scan bytes enter via hist_q.
	always_ff @(posedge clk) begin
		aligned_q <= aligned_d;
	end

	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			hit[p] = (aligned_q[p] == hist_q);
		end
	end

	assign hist_out   = hist_q;
	assign store_byte = store_q;

endmodule

>>> rtl/core/amat_align.sv
// Finds the effective length of one stored pattern (up to its first zero
// byte) and right-aligns the reversed pattern onto the history window.
// Depends on amat_pkg.
`timescale 1ns / 1ps

module amat_align import amat_pkg::*; #(
	parameter  int CELLS = 32,
	localparam int LEN_W = $clog2(CELLS + 1)
) (
	input  logic [CELLS*BYTE_W-1:0] pattern,
	input  logic [LEN_W-1:0]        raw_len,
	output logic [LEN_W-1:0]        eff_len,
	output logic [CELLS*BYTE_W-1:0] aligned
);

	logic [CELLS*BYTE_W-1:0] rev;
	logic [CELLS*BYTE_W-1:0] shifted;
	logic [LEN_W-1:0]        len;
	logic [LEN_W-1:0]        gap;

	always_comb begin
		len = raw_len;
		for (int k = CELLS - 1; k >= 0; k--) begin
			if (LEN_W'(k) < raw_len && pattern[k*BYTE_W +: BYTE_W] == '0) begin
				len = LEN_W'(k);
			end
		end
	end

	// Byte j of the result is pattern byte len-1-j: reverse, then drop the
	// CELLS-len bytes that lie beyond the pattern end.
	always_comb begin
		for (int i = 0; i < CELLS; i++) begin
			rev[i*BYTE_W +: BYTE_W] = pattern[(CELLS-1-i)*BYTE_W +: BYTE_W];
		end
		gap = LEN_W'(CELLS) - len;
		shifted = rev;
		for (int b = 0; b < LEN_W; b++) begin
			if (gap[b]) begin
				shifted = shifted >> (BYTE_W << b);
			end
		end
	end

	assign eff_len = len;
	assign aligned = shifted;

endmodule

>>> rtl/core/all_patterns_substring_matcher.sv
// Top level of the all-patterns substring matcher: history cell chain,
// pattern alignment, found flags and the result register.
// Depends on amat_pkg, amat_item_if, amat_result_if, amat_cell, amat_align.
`timescale 1ns / 1ps

// Input transfers (pattern load, content byte or end of content) may follow back
// to back; a load is seen by a scan byte in the next transfer. Content bytes
// shift into a chain of cells, one per pattern position, and every stored pattern
// is compared against the newest bytes in parallel, so the rate is one byte per
// cycle unless input is stalled. The found flags are updated by the compare stage
// after each shifting scan byte. An end-of-content transfer loads the result
// register, which is offered on the next cycle; input is stalled only while that
// register holds a result that has not been taken. Stored patterns survive an
// end of content; the history, found flags and stop flag are cleared by it.
module all_patterns_substring_matcher import amat_pkg::*; #(
	parameter int NUM_PATTERNS = 8,
	parameter int PATTERN_LEN  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	amat_item_if.sink          item,
	amat_result_if.source      result,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int CELLS = (PATTERN_LEN < MAX_CELLS) ? PATTERN_LEN : MAX_CELLS;
	localparam int LEN_W = $clog2(CELLS + 1);

	cell_ctl_t ctl;
	logic      in_acc;
	logic      end_acc;

	logic [COUNT_W-1:0]      pcount_q;
	logic [LEN_W-1:0]        len_q [NUM_PATTERNS];
	logic [LEN_W-1:0]        eff_q [NUM_PATTERNS];
	logic [NUM_PATTERNS-1:0] found_q;
	logic                    stopped_q;
	logic                    scan_s1;

	logic                    out_valid_q;
	logic                    out_detected_q;
	logic [MASK_W-1:0]       out_mask_q;
	logic                    out_stopped_q;

	logic [BYTE_W-1:0]       chain_w   [CELLS];
	logic [BYTE_W-1:0]       store_w   [CELLS][NUM_PATTERNS];
	logic [BYTE_W-1:0]       aligned_w [CELLS][NUM_PATTERNS];
	logic [NUM_PATTERNS-1:0] hit_w     [CELLS];
	logic [CELLS*BYTE_W-1:0] pat_vec   [NUM_PATTERNS];
	logic [CELLS*BYTE_W-1:0] al_vec    [NUM_PATTERNS];
	logic [LEN_W-1:0]        eff_w     [NUM_PATTERNS];

	logic [NUM_PATTERNS-1:0] match;
	logic [NUM_PATTERNS-1:0] found_now;
	logic                    all_found;
	logic [MASK_W-1:0]       mask_now;

	assign item.ready = !out_valid_q || result.ready;
	assign in_acc     = item.valid && item.ready;
	assign end_acc    = in_acc && item.func == FUNC_END;

	always_comb begin
		ctl.shift     = in_acc && item.func == FUNC_SCAN && !stopped_q
		                && item.byte_value != '0;
		ctl.clear     = end_acc;
		ctl.load      = in_acc && item.func == FUNC_LOAD
		                && int'(item.pattern_index) < NUM_PATTERNS
		                && int'(item.pattern_pos) < CELLS;
		ctl.load_idx  = item.pattern_index;
		ctl.load_pos  = item.pattern_pos;
		ctl.load_byte = item.byte_value;
	end

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		logic [BYTE_W-1:0] hist_in;
		if (j == 0) begin : g_head
			assign hist_in = item.byte_value;
		end else begin : g_link
			assign hist_in = chain_w[j-1];
		end

		amat_cell #(
			.NUM_PATTERNS (NUM_PATTERNS),
			.INDEX        (j)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.hist_in    (hist_in),
			.hist_out   (chain_w[j]),
			.store_byte (store_w[j]),
			.aligned_d  (aligned_w[j]),
			.hit        (hit_w[j])
		);

		for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_wire
			assign pat_vec[p][j*BYTE_W +: BYTE_W] = store_w[j][p];
			assign aligned_w[j][p] = al_vec[p][j*BYTE_W +: BYTE_W];
		end
	end

	for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_align
		amat_align #(
			.CELLS (CELLS)
		) u_align (
			.pattern (pat_vec[p]),
			.raw_len (len_q[p]),
			.eff_len (eff_w[p]),
			.aligned (al_vec[p])
		);
	end

	// A pattern matches when every cell inside its effective length agrees.
	// The empty test uses the current store, so a load just before the end counts.
	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			match[p] = (eff_q[p] != '0);
			for (int j = 0; j < CELLS; j++) begin
				if (LEN_W'(j) < eff_q[p] && !hit_w[j][p]) begin
					match[p] = 1'b0;
				end
			end
			found_now[p] = found_q[p] || (scan_s1 && match[p]) || eff_w[p] == '0;
		end
	end

	always_comb begin
		all_found = 1'b1;
		mask_now  = '0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			if (p < int'(pcount_q) && !found_now[p]) begin
				all_found = 1'b0;
			end
		end
		for (int p = 0; p < NUM_PATTERNS && p < MASK_W; p++) begin
			mask_now[p] = found_now[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= '0;
			found_q   <= '0;
			stopped_q <= 1'b0;
			scan_s1   <= 1'b0;
			for (int p = 0; p < NUM_PATTERNS; p++) begin
				len_q[p] <= '0;
				eff_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				pcount_q <= cfg_wdata;
			end
			for (int p = 0; p < NUM_PATTERNS; p++) begin
				eff_q[p] <= eff_w[p];
				if (ctl.load && item.last && int'(item.pattern_index) == p) begin
					len_q[p] <= LEN_W'(item.pattern_pos) + LEN_W'(1);
				end
			end
			scan_s1 <= ctl.shift;
			if (end_acc) begin
				found_q   <= '0;
				stopped_q <= 1'b0;
			end else begin
				if (scan_s1) begin
					found_q <= found_q | match;
				end
				if (in_acc && item.func == FUNC_SCAN && item.byte_value == '0) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_acc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_acc) begin
			out_detected_q <= all_found;
			out_mask_q     <= mask_now;
			out_stopped_q  <= stopped_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.detected        = out_detected_q;
	assign result.found_mask      = out_mask_q;
	assign result.content_stopped = out_stopped_q;

	// The end of content wipes the found flags and no match leaks in after it.
	a_clear_found: assert property (@(posedge clk) disable iff (!arst_n)
		end_acc |=> found_q == '0)
		else $error("found flags not cleared after end of content");

	// Once stopped, no content byte may enter the history.
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !ctl.shift)
		else $error("history shifted while stopped");

	// Every end-of-content transfer leaves a result on offer.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		end_acc |=> result.valid)
		else $error("end of content produced no result");

	// The compare stage follows every history shift.
	a_compare_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |=> scan_s1)
		else $error("history shift without compare stage");

endmodule
